@@ rtl/core/chassis_velocity_mixer_macros.svh @@
// assertion macros shared by the chassis velocity mixer rtl
// expects clk and rst_n in the scope of every use
`ifndef CHASSIS_VELOCITY_MIXER_MACROS_SVH
`define CHASSIS_VELOCITY_MIXER_MACROS_SVH

`ifndef SYNTHESIS
`define CVM_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("chassis velocity mixer check failed");
`define CVM_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("chassis velocity mixer check failed");
`else
`define CVM_ASSERT_IMPL(name, ante, cons)
`define CVM_ASSERT_NEXT(name, ante, cons)
`endif

`endif

@@ rtl/core/cvm_pkg.sv @@
// types, constants and the sine table generator of the chassis velocity mixer
// no dependencies
package cvm_pkg;

    localparam int NSTAGE         = 10;
    localparam int FULL_CIRCLE    = 36000;
    localparam int QUARTER_CIRCLE = 9000;
    localparam int IN_W           = 104;
    localparam int OUT_W          = 96;

    localparam logic [63:0] TWO_PI_Q28 = 64'd1686629713;
    localparam logic [15:0] SCALE_ONE  = 16'h8000;

    localparam logic [1:0] CFG_WHEEL_GAIN        = 2'd0;
    localparam logic [1:0] CFG_CAP_MIN_VOLTAGE   = 2'd1;
    localparam logic [1:0] CFG_BUFFER_FULL_LEVEL = 2'd2;

    typedef logic [NSTAGE-1:0]  stage_en_t;
    typedef logic signed [16:0] trig_t;
    typedef logic signed [17:0] ref_t;

    // q15 sine of a q32 phase, taylor series in q30, evaluated at elaboration
    function automatic trig_t sine_from_phase(input logic [63:0] phase);
        logic [63:0]        p;
        logic [63:0]        x;
        logic [63:0]        t;
        logic signed [63:0] sum;
        logic signed [63:0] r;
        logic               neg;
        p   = phase;
        neg = 1'b0;
        if (p >= 64'h8000_0000)
        begin
            neg = 1'b1;
            p   = p - 64'h8000_0000;
        end
        if (p > 64'h4000_0000)
            p = 64'h8000_0000 - p;
        x   = (p * TWO_PI_Q28) >> 30;
        sum = $signed(x);
        t   = x;
        for (int k = 1; k <= 8; k++)
        begin
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            t = t / 64'((2 * k) * (2 * k + 1));
            if (k[0])
                sum = sum - $signed(t);
            else
                sum = sum + $signed(t);
        end
        r = (sum >= 0) ? ((sum + 64'sd16384) >>> 15) : 64'sd0;
        if (r > 64'sd32768)
            r = 64'sd32768;
        return neg ? trig_t'(-r) : trig_t'(r);
    endfunction

endpackage

@@ rtl/core/cvm_sine_lookup.sv @@
// angle wrap, table index by reciprocal multiply, and sine/cosine table read
// depends on cvm_pkg; occupies pipeline stages one to four
module cvm_sine_lookup #(
    parameter int SINE_TABLE_ENTRIES = 1024
) (
    input  logic                    clk,
    input  cvm_pkg::stage_en_t      stage_en,
    input  logic signed [15:0]      frame_angle,
    output cvm_pkg::trig_t          sin_val,
    output cvm_pkg::trig_t          cos_val
);

    localparam int IDX_W   = $clog2(SINE_TABLE_ENTRIES);
    localparam int CMP_W   = IDX_W + 17;
    localparam int RECIP_W = IDX_W + 17;
    localparam int PROD_W  = 16 + RECIP_W;

    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((64'(SINE_TABLE_ENTRIES) << 32) / cvm_pkg::FULL_CIRCLE);
    localparam logic [CMP_W-1:0] N_CMP      = CMP_W'(SINE_TABLE_ENTRIES);
    localparam logic [CMP_W-1:0] CIRCLE_CMP = CMP_W'(cvm_pkg::FULL_CIRCLE);

    cvm_pkg::trig_t sine_rom [SINE_TABLE_ENTRIES];

    for (genvar i = 0; i < SINE_TABLE_ENTRIES; i++)
    begin : g_rom
        localparam logic [63:0] PHASE = (64'(i) << 32) / SINE_TABLE_ENTRIES;
        assign sine_rom[i] = cvm_pkg::sine_from_phase(PHASE);
    end

    // lane 0 is the sine angle, lane 1 the cosine angle
    logic [15:0]       ang_next [2];
    logic [15:0]       ang_reg  [2];
    logic [IDX_W-1:0]  q0_reg   [2];
    logic [CMP_W-1:0]  an_reg   [2];
    logic [IDX_W-1:0]  idx_reg  [2];
    cvm_pkg::trig_t    trig_reg [2];
    logic [15:0]       angle_bits;
    logic [16:0]       quad_sum;

    always_comb
    begin
        angle_bits  = frame_angle;
        ang_next[0] = frame_angle[15] ? (angle_bits + 16'(cvm_pkg::FULL_CIRCLE)) : angle_bits;
        quad_sum    = {1'b0, ang_next[0]} + 17'(cvm_pkg::QUARTER_CIRCLE);
        ang_next[1] = (quad_sum >= 17'(cvm_pkg::FULL_CIRCLE))
                    ? 16'(quad_sum - 17'(cvm_pkg::FULL_CIRCLE)) : quad_sum[15:0];
    end

    for (genvar l = 0; l < 2; l++)
    begin : g_lane
        logic [PROD_W-1:0] prod;
        logic [CMP_W-1:0]  cand;

        assign prod = PROD_W'(ang_reg[l]) * PROD_W'(RECIP);
        assign cand = CMP_W'(q0_reg[l]) + CMP_W'(1);

        always_ff @(posedge clk)
        begin
            if (stage_en[0])
                ang_reg[l] <= ang_next[l];
            // estimate is exact or one low
            if (stage_en[1])
            begin
                q0_reg[l] <= prod[32 +: IDX_W];
                an_reg[l] <= CMP_W'(ang_reg[l]) * N_CMP;
            end
            if (stage_en[2])
                idx_reg[l] <= (cand * CIRCLE_CMP <= an_reg[l]) ? IDX_W'(cand) : q0_reg[l];
            if (stage_en[3])
                trig_reg[l] <= sine_rom[idx_reg[l]];
        end
    end

    assign sin_val = trig_reg[0];
    assign cos_val = trig_reg[1];

endmodule

@@ rtl/core/cvm_scale_div.sv @@
// capacitor decision and pipelined q15 power scale divider
// depends on cvm_pkg; occupies pipeline stages one to five
module cvm_scale_div (
    input  logic               clk,
    input  cvm_pkg::stage_en_t stage_en,
    input  logic               cap_request,
    input  logic [15:0]        cap_voltage,
    input  logic [15:0]        stored_energy,
    input  logic [15:0]        cap_min_voltage,
    input  logic [7:0]         buffer_full_level,
    output logic [15:0]        power_scale,
    output logic               cap_active
);

    // {remainder, quotient}
    typedef logic [22:0] div_acc_t;

    function automatic div_acc_t div_step(input div_acc_t acc, input logic [7:0] divisor);
        logic [8:0]  shifted;
        logic [7:0]  rem;
        logic [14:0] quo;
        shifted = {acc[22:15], 1'b0};
        quo     = {acc[13:0], 1'b0};
        if (shifted >= {1'b0, divisor})
        begin
            rem    = 8'(shifted - {1'b0, divisor});
            quo[0] = 1'b1;
        end
        else
        begin
            rem = shifted[7:0];
        end
        return {rem, quo};
    endfunction

    div_acc_t    acc_reg  [4];
    logic        full_reg [4];
    logic        cap_reg  [4];
    div_acc_t    acc_next [4];
    logic        cap_next;
    logic [15:0] scale_reg;
    logic        cap_out_reg;

    // remainder starts as the energy itself, valid whenever no full scale applies
    always_comb
    begin
        cap_next = cap_request && (cap_voltage > cap_min_voltage);
        for (int j = 1; j < 4; j++)
        begin
            acc_next[j] = acc_reg[j-1];
            for (int s = 0; s < 4; s++)
                acc_next[j] = div_step(acc_next[j], buffer_full_level);
        end
        acc_next[0] = acc_reg[3];
        for (int s = 0; s < 3; s++)
            acc_next[0] = div_step(acc_next[0], buffer_full_level);
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            acc_reg[0]  <= {stored_energy[7:0], 15'd0};
            cap_reg[0]  <= cap_next;
            full_reg[0] <= cap_next || (stored_energy >= {8'd0, buffer_full_level});
        end
        for (int j = 1; j < 4; j++)
        begin
            if (stage_en[j])
            begin
                acc_reg[j]  <= acc_next[j];
                cap_reg[j]  <= cap_reg[j-1];
                full_reg[j] <= full_reg[j-1];
            end
        end
        if (stage_en[4])
        begin
            scale_reg   <= full_reg[3] ? cvm_pkg::SCALE_ONE : {1'b0, acc_next[0][14:0]};
            cap_out_reg <= cap_reg[3];
        end
    end

    assign power_scale = scale_reg;
    assign cap_active  = cap_out_reg;

endmodule

@@ rtl/core/cvm_wheel_mix.sv @@
// frame rotation, wheel mixing, power scaling and saturation
// depends on cvm_pkg; occupies pipeline stages five to ten
module cvm_wheel_mix (
    input  logic               clk,
    input  cvm_pkg::stage_en_t stage_en,
    input  logic signed [15:0] vel_x,
    input  logic signed [15:0] vel_y,
    input  logic signed [15:0] yaw_rate,
    input  cvm_pkg::trig_t     sin_val,
    input  cvm_pkg::trig_t     cos_val,
    input  logic [15:0]        power_scale,
    input  logic [15:0]        wheel_gain,
    output cvm_pkg::ref_t      ref_left_front,
    output cvm_pkg::ref_t      ref_right_front,
    output cvm_pkg::ref_t      ref_left_back,
    output cvm_pkg::ref_t      ref_right_back
);

    localparam logic signed [37:0] REF_MAX = 38'sd131071;
    localparam logic signed [37:0] REF_MIN = -38'sd131072;

    // products: x*cos, y*sin, x*sin, y*cos
    logic signed [32:0] prod_reg [4];
    logic signed [15:0] yaw5_reg;
    logic signed [15:0] yaw6_reg;
    logic signed [15:0] yaw7_reg;
    logic signed [17:0] cx_reg;
    logic signed [17:0] cy_reg;
    logic [15:0]        scale6_reg;
    logic [15:0]        scale7_reg;
    logic [15:0]        scale8_reg;
    logic signed [33:0] sum_x;
    logic signed [33:0] sum_y;
    logic signed [18:0] d_next [4];
    logic signed [35:0] gd_reg [4];
    logic signed [20:0] w_reg  [4];
    logic signed [37:0] ws_reg [4];
    cvm_pkg::ref_t      ref_reg [4];

    always_comb
    begin
        sum_x     = 34'(prod_reg[0]) - 34'(prod_reg[1]) + 34'sd16384;
        sum_y     = 34'(prod_reg[2]) + 34'(prod_reg[3]) + 34'sd16384;
        // wheel order: left front, right front, left back, right back
        d_next[0] = 19'(cy_reg) - 19'(cx_reg);
        d_next[1] = 19'(cx_reg) + 19'(cy_reg);
        d_next[2] = 19'(cx_reg) - 19'(cy_reg);
        d_next[3] = -19'(cx_reg) - 19'(cy_reg);
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[4])
        begin
            prod_reg[0] <= 33'(vel_x) * 33'(cos_val);
            prod_reg[1] <= 33'(vel_y) * 33'(sin_val);
            prod_reg[2] <= 33'(vel_x) * 33'(sin_val);
            prod_reg[3] <= 33'(vel_y) * 33'(cos_val);
            yaw5_reg    <= yaw_rate;
        end
        if (stage_en[5])
        begin
            cx_reg     <= 18'(sum_x >>> 15);
            cy_reg     <= 18'(sum_y >>> 15);
            yaw6_reg   <= yaw5_reg;
            scale6_reg <= power_scale;
        end
        if (stage_en[6])
        begin
            yaw7_reg   <= yaw6_reg;
            scale7_reg <= scale6_reg;
        end
        if (stage_en[7])
            scale8_reg <= scale7_reg;
    end

    for (genvar i = 0; i < 4; i++)
    begin : g_wheel
        logic signed [35:0] gd_round;
        logic signed [37:0] ws_round;
        logic signed [37:0] ref_full;

        assign gd_round = gd_reg[i] + 36'sd16384;
        assign ws_round = ws_reg[i] + 38'sd16384;
        assign ref_full = ws_round >>> 15;

        always_ff @(posedge clk)
        begin
            if (stage_en[6])
                gd_reg[i] <= 36'(d_next[i]) * 36'($signed({1'b0, wheel_gain}));
            if (stage_en[7])
                w_reg[i] <= 21'(gd_round >>> 15) + 21'(yaw7_reg);
            if (stage_en[8])
                ws_reg[i] <= 38'(w_reg[i]) * 38'($signed({1'b0, scale8_reg}));
            if (stage_en[9])
            begin
                if (ref_full > REF_MAX)
                    ref_reg[i] <= 18'(REF_MAX);
                else if (ref_full < REF_MIN)
                    ref_reg[i] <= 18'(REF_MIN);
                else
                    ref_reg[i] <= 18'(ref_full);
            end
        end
    end

    assign ref_left_front  = ref_reg[0];
    assign ref_right_front = ref_reg[1];
    assign ref_left_back   = ref_reg[2];
    assign ref_right_back  = ref_reg[3];

endmodule

@@ rtl/core/chassis_velocity_mixer.sv @@
// chassis velocity mixer top level: stream ports, config registers, stage control
// depends on cvm_pkg, cvm_sine_lookup, cvm_scale_div, cvm_wheel_mix and the macros header
//
// usage:
//   s_* carries one velocity command beat, m_* one beat of four wheel references
//   plus motor, capacitor and scale status. cfg_we/cfg_index/cfg_data writes
//   wheel_gain (0), cap_min_voltage (1) and buffer_full_level (2);
//   other indexes are dropped. write config only while no beat is in flight.
//   an accepted input beat passes through ten register stages in all before
//   m_tvalid rises.
//   throughput: one beat per cycle while m_tready is high, set by the ten-stage
//   pipeline with at most one multiplier level per stage; the q15 power divider
//   retires four quotient bits in each of stages two to four, three in stage five.
//   reset clears all stage valid bits and loads the default config values.
//   when m_tready is low the output beat holds and earlier stages keep filling
//   bubbles; s_tready drops only once all ten stages hold a beat.
`include "chassis_velocity_mixer_macros.svh"

module chassis_velocity_mixer #(
    parameter int SINE_TABLE_ENTRIES = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // vel_x, vel_y, yaw_rate, frame_angle, zero_force, cap_request,
    // cap_voltage, stored_energy, zero pad
    input  logic [cvm_pkg::IN_W-1:0]   s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // ref_left_front, ref_right_front, ref_left_back, ref_right_back,
    // motors_on, cap_active, power_scale, zero pad
    output logic [cvm_pkg::OUT_W-1:0]  m_tdata,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_index,
    input  logic [15:0]                cfg_data
);

    localparam int NST = cvm_pkg::NSTAGE;

    logic [15:0] wheel_gain_reg;
    logic [15:0] cap_min_voltage_reg;
    logic [7:0]  buffer_full_level_reg;

    logic [NST-1:0]     valid_reg;
    cvm_pkg::stage_en_t stage_en;

    logic signed [15:0] vel_x_reg    [4];
    logic signed [15:0] vel_y_reg    [4];
    logic signed [15:0] yaw_rate_reg [4];
    logic               zero_force_reg [NST];
    logic               cap_reg   [5:9];
    logic [15:0]        scale_reg [5:9];

    cvm_pkg::trig_t sin_val;
    cvm_pkg::trig_t cos_val;
    logic [15:0]    div_scale;
    logic           div_cap;
    cvm_pkg::ref_t  ref_left_front;
    cvm_pkg::ref_t  ref_right_front;
    cvm_pkg::ref_t  ref_left_back;
    cvm_pkg::ref_t  ref_right_back;

    // a stage loads when empty or when the next one moves on
    always_comb
    begin
        stage_en[NST-1] = ~valid_reg[NST-1] | m_tready;
        for (int k = NST - 2; k >= 0; k--)
            stage_en[k] = ~valid_reg[k] | stage_en[k+1];
    end

    assign s_tready = stage_en[0];
    assign m_tvalid = valid_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_en[0])
                valid_reg[0] <= s_tvalid;
            for (int k = 1; k < NST; k++)
            begin
                if (stage_en[k])
                    valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheel_gain_reg        <= 16'd32768;
            cap_min_voltage_reg   <= 16'd12000;
            buffer_full_level_reg <= 8'd50;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cvm_pkg::CFG_WHEEL_GAIN:        wheel_gain_reg        <= cfg_data;
                cvm_pkg::CFG_CAP_MIN_VOLTAGE:   cap_min_voltage_reg   <= cfg_data;
                cvm_pkg::CFG_BUFFER_FULL_LEVEL: buffer_full_level_reg <= cfg_data[7:0];
                default:                        ;
            endcase
        end
    end

    // payload carried alongside the units
    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            vel_x_reg[0]      <= s_tdata[15:0];
            vel_y_reg[0]      <= s_tdata[31:16];
            yaw_rate_reg[0]   <= s_tdata[47:32];
            zero_force_reg[0] <= s_tdata[64];
        end
        for (int k = 1; k < 4; k++)
        begin
            if (stage_en[k])
            begin
                vel_x_reg[k]    <= vel_x_reg[k-1];
                vel_y_reg[k]    <= vel_y_reg[k-1];
                yaw_rate_reg[k] <= yaw_rate_reg[k-1];
            end
        end
        for (int k = 1; k < NST; k++)
        begin
            if (stage_en[k])
                zero_force_reg[k] <= zero_force_reg[k-1];
        end
        if (stage_en[5])
        begin
            cap_reg[5]   <= div_cap;
            scale_reg[5] <= div_scale;
        end
        for (int k = 6; k < NST; k++)
        begin
            if (stage_en[k])
            begin
                cap_reg[k]   <= cap_reg[k-1];
                scale_reg[k] <= scale_reg[k-1];
            end
        end
    end

    cvm_sine_lookup #(
        .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES)
    ) u_sine (
        .clk         (clk),
        .stage_en    (stage_en),
        .frame_angle (s_tdata[63:48]),
        .sin_val     (sin_val),
        .cos_val     (cos_val)
    );

    cvm_scale_div u_div (
        .clk               (clk),
        .stage_en          (stage_en),
        .cap_request       (s_tdata[65]),
        .cap_voltage       (s_tdata[81:66]),
        .stored_energy     (s_tdata[97:82]),
        .cap_min_voltage   (cap_min_voltage_reg),
        .buffer_full_level (buffer_full_level_reg),
        .power_scale       (div_scale),
        .cap_active        (div_cap)
    );

    cvm_wheel_mix u_mix (
        .clk             (clk),
        .stage_en        (stage_en),
        .vel_x           (vel_x_reg[3]),
        .vel_y           (vel_y_reg[3]),
        .yaw_rate        (yaw_rate_reg[3]),
        .sin_val         (sin_val),
        .cos_val         (cos_val),
        .power_scale     (div_scale),
        .wheel_gain      (wheel_gain_reg),
        .ref_left_front  (ref_left_front),
        .ref_right_front (ref_right_front),
        .ref_left_back   (ref_left_back),
        .ref_right_back  (ref_right_back)
    );

    assign m_tdata = {6'd0, scale_reg[9], cap_reg[9], ~zero_force_reg[NST-1],
                      ref_right_back, ref_left_back, ref_right_front, ref_left_front};

    `CVM_ASSERT_IMPL(a_ready_when_out_free, !m_tvalid, s_tready)
    `CVM_ASSERT_IMPL(a_full_stall_blocks, (&valid_reg) && !m_tready, !s_tready)
    `CVM_ASSERT_IMPL(a_cap_full_scale, m_tvalid && cap_reg[9], scale_reg[9] == cvm_pkg::SCALE_ONE)
    `CVM_ASSERT_IMPL(a_out_from_last_stage, $rose(m_tvalid), $past(valid_reg[NST-2]))
    `CVM_ASSERT_NEXT(a_accept_fills_first, s_tvalid && s_tready, valid_reg[0])

endmodule

@@ tb/wheel_ref_checker.sv @@
// checker for the chassis velocity mixer: watches the command, result and config ports,
// predicts the four wheel references of every command and compares them in order
// depends on cvm_pkg for the register indexes, the reference type and the port widths
module wheel_ref_checker #(
    parameter int SINE_TABLE_ENTRIES = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [cvm_pkg::IN_W-1:0]  s_tdata,
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [cvm_pkg::OUT_W-1:0] m_tdata,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [15:0]               cfg_data,
    output int                        mismatch_count,
    output int                        pending_count
);

    localparam longint REF_MAX = 131071;
    localparam longint REF_MIN = -131072;

    typedef struct packed {
        logic [5:0]         pad;
        logic [15:0]        stored_energy;
        logic [15:0]        cap_voltage;
        logic               cap_request;
        logic               zero_force;
        logic signed [15:0] frame_angle;
        logic signed [15:0] yaw_rate;
        logic signed [15:0] vel_y;
        logic signed [15:0] vel_x;
    } drive_cmd_t;

    typedef struct packed {
        logic [5:0]    pad;
        logic [15:0]   power_scale;
        logic          cap_active;
        logic          motors_on;
        cvm_pkg::ref_t ref_right_back;
        cvm_pkg::ref_t ref_left_back;
        cvm_pkg::ref_t ref_right_front;
        cvm_pkg::ref_t ref_left_front;
    } wheel_refs_t;

    int          sine_lut [SINE_TABLE_ENTRIES];
    int          wheel_gain        = 32768;
    int          cap_min_voltage   = 12000;
    int          buffer_full_level = 50;
    wheel_refs_t expected_refs [$];

    // q15 sine of table slot idx: quarter-turn fold, taylor series in q30
    function automatic int table_sine(int idx);
        logic [63:0] phase;
        logic [63:0] x;
        logic [63:0] t;
        longint      sum;
        longint      mag;
        bit          neg;
        int          k;
        phase = (64'(idx) << 32) / 64'(SINE_TABLE_ENTRIES);
        neg   = 1'b0;
        if (phase >= 64'h8000_0000)
        begin
            neg   = 1'b1;
            phase = phase - 64'h8000_0000;
        end
        if (phase > 64'h4000_0000)
            phase = 64'h8000_0000 - phase;
        x   = (phase * cvm_pkg::TWO_PI_Q28) >> 30;
        sum = longint'(x);
        t   = x;
        for (k = 1; k <= 8; k++)
        begin
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            t = t / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
                sum = sum - longint'(t);
            else
                sum = sum + longint'(t);
        end
        mag = (sum >= 0) ? ((sum + 16384) >>> 15) : 0;
        if (mag > 32768)
            mag = 32768;
        return neg ? -int'(mag) : int'(mag);
    endfunction

    // divide by 2^15, rounding half toward +inf
    function automatic longint round_q15(longint v);
        return (v + 16384) >>> 15;
    endfunction

    function automatic int angle_slot(int ang);
        return (ang * SINE_TABLE_ENTRIES) / cvm_pkg::FULL_CIRCLE;
    endfunction

    function automatic wheel_refs_t predict_wheel_refs(drive_cmd_t cmd);
        wheel_refs_t   refs;
        int            ang;
        int            ang_c;
        int            scale;
        longint        s;
        longint        c;
        longint        cx;
        longint        cy;
        longint        w;
        longint        d [4];
        cvm_pkg::ref_t r [4];
        bit            cap_on;
        int            i;
        ang = int'(cmd.frame_angle) % cvm_pkg::FULL_CIRCLE;
        if (ang < 0)
            ang = ang + cvm_pkg::FULL_CIRCLE;
        ang_c = ang + cvm_pkg::QUARTER_CIRCLE;
        if (ang_c >= cvm_pkg::FULL_CIRCLE)
            ang_c = ang_c - cvm_pkg::FULL_CIRCLE;
        s = sine_lut[angle_slot(ang)];
        c = sine_lut[angle_slot(ang_c)];

        // gimbal frame into chassis frame
        cx = round_q15(longint'(cmd.vel_x) * c - longint'(cmd.vel_y) * s);
        cy = round_q15(longint'(cmd.vel_x) * s + longint'(cmd.vel_y) * c);
        d[0] = -cx + cy;
        d[1] =  cx + cy;
        d[2] =  cx - cy;
        d[3] = -cx - cy;

        cap_on = cmd.cap_request && (int'(cmd.cap_voltage) > cap_min_voltage);
        if (cap_on || int'(cmd.stored_energy) >= buffer_full_level)
            scale = 32768;
        else
            scale = (int'(cmd.stored_energy) * 32768) / buffer_full_level;

        for (i = 0; i < 4; i++)
        begin
            w = round_q15(d[i] * wheel_gain) + longint'(cmd.yaw_rate);
            w = round_q15(w * scale);
            if (w > REF_MAX)
                w = REF_MAX;
            else if (w < REF_MIN)
                w = REF_MIN;
            r[i] = cvm_pkg::ref_t'(w);
        end

        refs                 = '0;
        refs.ref_left_front  = r[0];
        refs.ref_right_front = r[1];
        refs.ref_left_back   = r[2];
        refs.ref_right_back  = r[3];
        refs.motors_on       = !cmd.zero_force;
        refs.cap_active      = cap_on;
        refs.power_scale     = 16'(scale);
        return refs;
    endfunction

    task automatic compare_field(string name, logic signed [63:0] want,
                                 logic signed [63:0] got);
        if (got !== want)
        begin
            $error("%s expected %0d got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_result(wheel_refs_t got);
        wheel_refs_t want;
        if (expected_refs.size() == 0)
        begin
            $error("result beat with no command pending");
            mismatch_count++;
        end
        else
        begin
            want = expected_refs.pop_front();
            compare_field("ref_left_front", want.ref_left_front, got.ref_left_front);
            compare_field("ref_right_front", want.ref_right_front, got.ref_right_front);
            compare_field("ref_left_back", want.ref_left_back, got.ref_left_back);
            compare_field("ref_right_back", want.ref_right_back, got.ref_right_back);
            compare_field("motors_on", want.motors_on, got.motors_on);
            compare_field("cap_active", want.cap_active, got.cap_active);
            compare_field("power_scale", want.power_scale, got.power_scale);
        end
    endtask

    initial
    begin
        for (int i = 0; i < SINE_TABLE_ENTRIES; i++)
            sine_lut[i] = table_sine(i);
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheel_gain        = 32768;
            cap_min_voltage   = 12000;
            buffer_full_level = 50;
            expected_refs.delete();
            mismatch_count    = 0;
            pending_count     = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_result(m_tdata);
            if (s_tvalid && s_tready)
                expected_refs.push_back(predict_wheel_refs(s_tdata));
            if (cfg_we)
            begin
                case (cfg_index)
                    cvm_pkg::CFG_WHEEL_GAIN:        wheel_gain        = int'(cfg_data);
                    cvm_pkg::CFG_CAP_MIN_VOLTAGE:   cap_min_voltage   = int'(cfg_data);
                    cvm_pkg::CFG_BUFFER_FULL_LEVEL: buffer_full_level = int'(cfg_data[7:0]);
                    default: ;
                endcase
            end
            pending_count = expected_refs.size();
        end
    end

endmodule

@@ tb/tb_top.sv @@
// top of the chassis velocity mixer testbench: clock, reset, command and result traffic,
// register writes and the verdict; checking lives in wheel_ref_checker
// depends on cvm_pkg, chassis_velocity_mixer and wheel_ref_checker
module tb_top;

    localparam int         SINE_ENTRIES    = 1024;
    localparam int         WATCHDOG_LIMIT  = 2000;
    localparam int         OUT_HOLD_CYCLES = 64;
    localparam int         TAIL_CYCLES     = 20;
    localparam logic [1:0] CFG_SPARE       = 2'd3;

    logic                      clk;
    logic                      rst_n;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [cvm_pkg::IN_W-1:0]  s_tdata;
    logic                      m_tvalid;
    logic                      m_tready;
    logic [cvm_pkg::OUT_W-1:0] m_tdata;
    logic                      cfg_we;
    logic [1:0]                cfg_index;
    logic [15:0]               cfg_data;

    int mismatch_count;
    int pending_count;
    int idle_cycles;
    int hold_requests;
    bit quiet;
    int cur_cap_min;
    int cur_full_level;

    chassis_velocity_mixer #(
        .SINE_TABLE_ENTRIES(SINE_ENTRIES)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    wheel_ref_checker #(
        .SINE_TABLE_ENTRIES(SINE_ENTRIES)
    ) u_wheel_ref_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatch_count(mismatch_count),
        .pending_count (pending_count)
    );

    initial
        clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // fields from the lowest bit up, zero pad on top
    function automatic logic [cvm_pkg::IN_W-1:0] make_cmd(int vx, int vy, int wz, int ang,
                                                          int zf, int cr, int cv, int be);
        return {6'd0, be[15:0], cv[15:0], cr[0], zf[0], ang[15:0], wz[15:0], vy[15:0],
                vx[15:0]};
    endfunction

    function automatic logic [cvm_pkg::IN_W-1:0] random_cmd();
        int ang;
        int cv;
        int be;
        if ($urandom_range(0, 3) != 0)
            ang = int'($urandom_range(0, 36000)) - 18000;
        else
            ang = int'($urandom_range(0, 65535));
        // voltage around the threshold half of the time
        if ($urandom_range(0, 1) == 0)
        begin
            cv = cur_cap_min + int'($urandom_range(0, 4)) - 2;
            if (cv < 0)
                cv = 0;
            else if (cv > 65535)
                cv = 65535;
        end
        else
            cv = int'($urandom_range(0, 65535));
        if ($urandom_range(0, 3) != 0)
            be = int'($urandom_range(0, cur_full_level + 5));
        else
            be = int'($urandom_range(0, 65535));
        return make_cmd(int'($urandom_range(0, 65535)), int'($urandom_range(0, 65535)),
                        int'($urandom_range(0, 65535)), ang,
                        ($urandom_range(0, 7) == 0) ? 1 : 0, int'($urandom_range(0, 1)),
                        cv, be);
    endfunction

    // entered and left at a falling edge
    task automatic send_cmd(logic [cvm_pkg::IN_W-1:0] beat);
        int gap;
        gap = quiet ? 0 : int'($urandom_range(0, 3));
        if (gap != 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = beat;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic run_random(int count);
        repeat (count) send_cmd(random_cmd());
    endtask

    task automatic settle_idle();
        s_tvalid = 1'b0;
        while (pending_count != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, int value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value[15:0];
        @(negedge clk);
        cfg_we    = 1'b0;
        if (idx == cvm_pkg::CFG_CAP_MIN_VOLTAGE)
            cur_cap_min = value & 16'hffff;
        else if (idx == cvm_pkg::CFG_BUFFER_FULL_LEVEL)
            cur_full_level = value & 8'hff;
    endtask

    // result side: random stalls, one long hold-off per request
    initial
    begin : result_sink
        int gap;
        int holds_served;
        holds_served = 0;
        m_tready     = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (holds_served != hold_requests)
            begin
                holds_served = hold_requests;
                m_tready     = 1'b0;
                repeat (OUT_HOLD_CYCLES) @(negedge clk);
            end
            gap = quiet ? 0 : int'($urandom_range(0, 3));
            if (gap != 0)
            begin
                m_tready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready = 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        cfg_we         = 1'b0;
        cfg_index      = cvm_pkg::CFG_WHEEL_GAIN;
        cfg_data       = '0;
        hold_requests  = 0;
        quiet          = 1'b0;
        cur_cap_min    = 12000;
        cur_full_level = 50;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed commands on the reset register values
        send_cmd(make_cmd(0, 0, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(32767, 0, 0, 0, 0, 0, 0, 50));
        send_cmd(make_cmd(-32768, 0, 0, 0, 0, 0, 0, 65535));
        send_cmd(make_cmd(0, 32767, 0, 9000, 0, 0, 0, 65535));
        send_cmd(make_cmd(0, -32768, 0, -9000, 0, 0, 0, 65535));
        send_cmd(make_cmd(32767, 32767, 32767, 4500, 0, 0, 0, 65535));
        send_cmd(make_cmd(-32768, -32768, -32768, 18000, 0, 0, 0, 65535));
        send_cmd(make_cmd(20000, -15000, 500, -18000, 0, 0, 0, 65535));
        // angles outside the half circle wrap around
        send_cmd(make_cmd(20000, 10000, -700, 32767, 0, 0, 0, 65535));
        send_cmd(make_cmd(20000, 10000, -700, -32768, 0, 0, 0, 65535));
        send_cmd(make_cmd(-9000, 31000, 0, 27000, 0, 0, 0, 65535));
        // zero force still carries the references
        send_cmd(make_cmd(12000, -8000, 3000, 6000, 1, 0, 0, 65535));
        // capacitor just above, at and without request
        send_cmd(make_cmd(16000, 16000, 100, 1000, 0, 1, 12001, 10));
        send_cmd(make_cmd(16000, 16000, 100, 1000, 0, 1, 12000, 10));
        send_cmd(make_cmd(16000, 16000, 100, 1000, 0, 0, 65535, 10));
        send_cmd(make_cmd(-25000, 7000, 2000, 12345, 0, 0, 0, 49));
        send_cmd(make_cmd(-25000, 7000, 2000, 12345, 0, 0, 0, 1));
        send_cmd(make_cmd(30000, -30000, -100, -4500, 1, 1, 65535, 0));
        send_cmd(make_cmd(12345, -23456, 1000, 13500, 0, 0, 0, 25));
        send_cmd(make_cmd(-1, -1, -1, -1, 1, 1, 65535, 65535));
        run_random(200);

        settle_idle();
        write_reg(cvm_pkg::CFG_WHEEL_GAIN, 23170);
        write_reg(cvm_pkg::CFG_CAP_MIN_VOLTAGE, 0);
        write_reg(cvm_pkg::CFG_BUFFER_FULL_LEVEL, 255);
        run_random(150);

        // stretch with no idling on either side
        settle_idle();
        write_reg(cvm_pkg::CFG_WHEEL_GAIN, 0);
        write_reg(cvm_pkg::CFG_CAP_MIN_VOLTAGE, 65535);
        write_reg(cvm_pkg::CFG_BUFFER_FULL_LEVEL, 1);
        quiet = 1'b1;
        run_random(100);
        quiet = 1'b0;

        // gain past unity saturates, full level zero never scales, spare index dropped
        settle_idle();
        write_reg(cvm_pkg::CFG_WHEEL_GAIN, 65535);
        write_reg(cvm_pkg::CFG_CAP_MIN_VOLTAGE, 12000);
        write_reg(cvm_pkg::CFG_BUFFER_FULL_LEVEL, 0);
        write_reg(CFG_SPARE, 16'h1234);
        run_random(100);

        settle_idle();
        write_reg(cvm_pkg::CFG_WHEEL_GAIN, int'($urandom_range(0, 65535)));
        write_reg(cvm_pkg::CFG_CAP_MIN_VOLTAGE, int'($urandom_range(0, 65535)));
        write_reg(cvm_pkg::CFG_BUFFER_FULL_LEVEL, int'($urandom_range(1, 255)));
        // long result stall so the pipeline backs up into the command side
        hold_requests = hold_requests + 1;
        run_random(250);

        settle_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
